// ----- hw/rtl/lspc_pkg.sv -----
`default_nettype none

package lspc_pkg;

    // Field widths
    localparam int unsigned RANGE_W    = 16;
    localparam int unsigned HALF_W     = 18;
    localparam int unsigned ANGLE_W    = 19;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 19;

    // Queue between classifier and accumulator
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = 2;
    localparam int unsigned QUEUE_CNT_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_LIMIT        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN_LIMIT        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_HALF_ANGLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_MIN_RANGE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_MAX_RANGE  = 3'd6;

    typedef enum logic [1:0] {
        STATUS_CLEAR   = 2'd0,
        STATUS_WARNING = 2'd1,
        STATUS_STOP    = 2'd2,
        STATUS_NO_DATA = 2'd3
    } status_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               range_is_finite;
        logic               last_of_scan;
    } in_item_t;

    typedef struct packed {
        status_t            proximity_status;
        logic [RANGE_W-1:0] nearest_mm;
    } out_item_t;

    // Classified sample handed from front to back
    typedef struct packed {
        logic               counts;
        logic [RANGE_W-1:0] range_mm;
        logic               last_of_scan;
    } cls_item_t;

    typedef struct packed {
        logic [RANGE_W-1:0]        stop_limit_mm;
        logic [RANGE_W-1:0]        warn_limit_mm;
        logic [HALF_W-1:0]         sector_half_angle;
        logic signed [ANGLE_W-1:0] start_angle;
        logic signed [ANGLE_W-1:0] angle_step;
        logic [RANGE_W-1:0]        sensor_min_range;
        logic [RANGE_W-1:0]        sensor_max_range;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        stop_limit_mm:     16'd350,
        warn_limit_mm:     16'd700,
        sector_half_angle: 18'd22877,
        start_angle:       -19'sd205887,
        angle_step:        19'sd101,
        sensor_min_range:  16'd0,
        sensor_max_range:  16'd65535
    };

endpackage

`default_nettype wire

// ----- hw/rtl/lspc_front.sv -----
`default_nettype none

module lspc_front import lspc_pkg::*; #(
    parameter int unsigned MAX_SAMPLES = 4096
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cfg_t      cfg,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           q_valid,
    input  wire logic      q_ready,
    output cls_item_t      q_data
);

    localparam int unsigned IDX_W  = $clog2(MAX_SAMPLES);
    localparam int unsigned PROD_W = IDX_W + ANGLE_W + 1;
    localparam int unsigned ANG_W  = PROD_W + 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);

    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     stg_valid_reg, stg_valid_next;
    in_item_t                 stg_item_reg, stg_item_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    logic                     accept;
    logic signed [ANG_W-1:0]  angle;
    logic [ANG_W-1:0]         mag;
    logic [ANG_W-1:0]         half_ext;
    logic                     in_sector;
    logic                     in_range;

    assign s_ready = !stg_valid_reg || q_ready;
    assign accept  = s_valid && s_ready;

    // Advance sample index, saturate at the last slot, restart after end of scan
    always_comb begin
        idx_next = idx_reg;
        if (accept) begin
            if (s_data.last_of_scan) begin
                idx_next = '0;
            end else if (idx_reg != IDX_LAST) begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    // Load the stage with the sample and its index times step
    always_comb begin
        stg_valid_next = stg_valid_reg;
        stg_item_next  = stg_item_reg;
        prod_next      = prod_reg;
        if (s_ready) begin
            stg_valid_next = s_valid;
            stg_item_next  = s_data;
            prod_next      = PROD_W'($signed({1'b0, idx_reg})) * PROD_W'(cfg.angle_step);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            stg_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            stg_valid_reg <= stg_valid_next;
        end
        stg_item_reg <= stg_item_next;
        prod_reg     <= prod_next;
    end

    // Classify: sector check on exact angle, range window, finiteness
    always_comb begin
        angle     = ANG_W'(prod_reg) + ANG_W'(cfg.start_angle);
        mag       = angle[ANG_W-1] ? ANG_W'(-angle) : ANG_W'(angle);
        half_ext  = ANG_W'(cfg.sector_half_angle);
        in_sector = mag <= half_ext;
        in_range  = (stg_item_reg.range_mm >= cfg.sensor_min_range) &&
                    (stg_item_reg.range_mm <= cfg.sensor_max_range);
    end

    assign q_valid             = stg_valid_reg;
    assign q_data.counts       = in_sector && in_range && stg_item_reg.range_is_finite;
    assign q_data.range_mm     = stg_item_reg.range_mm;
    assign q_data.last_of_scan = stg_item_reg.last_of_scan;

endmodule

`default_nettype wire

// ----- hw/rtl/lspc_queue.sv -----
`default_nettype none

module lspc_queue import lspc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire cls_item_t in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output cls_item_t      out_data
);

    cls_item_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   push;
    logic                   pop;

    assign in_ready  = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Move pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lspc_back.sv -----
`default_nettype none

module lspc_back import lspc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cfg_t      cfg,
    input  wire logic      q_valid,
    output logic           q_ready,
    input  wire cls_item_t q_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic [RANGE_W-1:0] min_reg, min_next;
    logic               seen_reg, seen_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg, out_next;

    logic               pop;
    logic [RANGE_W-1:0] min_upd;
    logic               seen_upd;
    out_item_t          result;

    // Take the next sample unless it closes a scan and the output slot is held
    assign q_ready = !q_data.last_of_scan || !out_valid_reg || m_ready;
    assign pop     = q_valid && q_ready;

    // Fold the sample into the running minimum and form the scan result
    always_comb begin
        min_upd  = (q_data.counts && (q_data.range_mm < min_reg)) ? q_data.range_mm : min_reg;
        seen_upd = seen_reg || q_data.counts;
        if (!seen_upd) begin
            result.proximity_status = STATUS_NO_DATA;
            result.nearest_mm       = '0;
        end else begin
            if (min_upd <= cfg.stop_limit_mm) begin
                result.proximity_status = STATUS_STOP;
            end else if (min_upd <= cfg.warn_limit_mm) begin
                result.proximity_status = STATUS_WARNING;
            end else begin
                result.proximity_status = STATUS_CLEAR;
            end
            result.nearest_mm = min_upd;
        end
    end

    // Update scan state and the output register
    always_comb begin
        min_next       = min_reg;
        seen_next      = seen_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (pop) begin
            if (q_data.last_of_scan) begin
                min_next       = '1;
                seen_next      = 1'b0;
                out_next       = result;
                out_valid_next = 1'b1;
            end else begin
                min_next  = min_upd;
                seen_next = seen_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg       <= '1;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            min_reg       <= min_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/lidar_sector_proximity_check_core.sv -----
// A sample's scan result passes the front stage register, the queue and the output register in turn.
// Throughput: one sample per cycle while the queue has room; the index multiply and sector compare are pipelined.
// A four-entry queue lets sample intake run on while a finished result waits.
// Reset (aresetn low, synchronous): scan state clears, control and configuration registers take their defaults.
`default_nettype none

module lidar_sector_proximity_check_core import lspc_pkg::*; #(
    parameter int unsigned MAX_SAMPLES = 4096
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data
);

    cfg_t      cfg_reg, cfg_next;
    logic      q_in_valid, q_in_ready;
    cls_item_t q_in_data;
    logic      q_out_valid, q_out_ready;
    cls_item_t q_out_data;

    assign cfg_ready = 1'b1;

    // Decode register writes; drop unknown indexes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_STOP_LIMIT:        cfg_next.stop_limit_mm     = cfg_data[RANGE_W-1:0];
                CFG_WARN_LIMIT:        cfg_next.warn_limit_mm     = cfg_data[RANGE_W-1:0];
                CFG_SECTOR_HALF_ANGLE: cfg_next.sector_half_angle = cfg_data[HALF_W-1:0];
                CFG_START_ANGLE:       cfg_next.start_angle       = $signed(cfg_data[ANGLE_W-1:0]);
                CFG_ANGLE_STEP:        cfg_next.angle_step        = $signed(cfg_data[ANGLE_W-1:0]);
                CFG_SENSOR_MIN_RANGE:  cfg_next.sensor_min_range  = cfg_data[RANGE_W-1:0];
                CFG_SENSOR_MAX_RANGE:  cfg_next.sensor_max_range  = cfg_data[RANGE_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lspc_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_in_valid),
        .q_ready (q_in_ready),
        .q_data  (q_in_data)
    );

    lspc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    lspc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_out_valid),
        .q_ready (q_out_ready),
        .q_data  (q_out_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ----- test/lspc_report_checker.sv -----
module lspc_report_checker import lspc_pkg::*; #(
    parameter int unsigned MAX_SAMPLES = 4096
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire in_item_t              s_data,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire out_item_t             m_data,
    output int                         error_count,
    output int                         reports_pending
);

    // Shadow registers and per-scan state
    cfg_t               regs;
    int unsigned        scan_index;
    logic [RANGE_W-1:0] scan_min;
    logic               scan_hit;
    out_item_t          expected_reports[$];

    always @(posedge aclk) begin : watch
        longint    angle;
        longint    magnitude;
        logic      counts;
        out_item_t report;
        out_item_t got;

        if (!aresetn) begin
            regs.stop_limit_mm     = 16'd350;
            regs.warn_limit_mm     = 16'd700;
            regs.sector_half_angle = 18'd22877;
            regs.start_angle       = -19'sd205887;
            regs.angle_step        = 19'sd101;
            regs.sensor_min_range  = 16'd0;
            regs.sensor_max_range  = 16'hFFFF;
            scan_index             = 0;
            scan_min               = '1;
            scan_hit               = 1'b0;
            expected_reports.delete();
            error_count            = 0;
        end else begin
            // Compare each finished report with the oldest prediction
            if (m_valid && m_ready) begin
                got = m_data;
                if (expected_reports.size() == 0) begin
                    $error("report with no scan end pending: proximity_status %0d nearest_mm %0d",
                           got.proximity_status, got.nearest_mm);
                    error_count++;
                end else begin
                    report = expected_reports.pop_front();
                    if (got.proximity_status !== report.proximity_status) begin
                        $error("proximity_status mismatch: expected %0d, actual %0d",
                               report.proximity_status, got.proximity_status);
                        error_count++;
                    end
                    if (got.nearest_mm !== report.nearest_mm) begin
                        $error("nearest_mm mismatch: expected %0d, actual %0d",
                               report.nearest_mm, got.nearest_mm);
                        error_count++;
                    end
                end
            end

            // Track register writes; drop unmapped indexes and bits above width
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_STOP_LIMIT:        regs.stop_limit_mm     = cfg_data[RANGE_W-1:0];
                    CFG_WARN_LIMIT:        regs.warn_limit_mm     = cfg_data[RANGE_W-1:0];
                    CFG_SECTOR_HALF_ANGLE: regs.sector_half_angle = cfg_data[HALF_W-1:0];
                    CFG_START_ANGLE:       regs.start_angle       = cfg_data[ANGLE_W-1:0];
                    CFG_ANGLE_STEP:        regs.angle_step        = cfg_data[ANGLE_W-1:0];
                    CFG_SENSOR_MIN_RANGE:  regs.sensor_min_range  = cfg_data[RANGE_W-1:0];
                    CFG_SENSOR_MAX_RANGE:  regs.sensor_max_range  = cfg_data[RANGE_W-1:0];
                    default: ;
                endcase
            end

            // Fold the sample into the scan minimum, exact angle without wrap
            if (s_valid && s_ready) begin
                angle = longint'($signed(regs.start_angle))
                      + longint'(scan_index) * longint'($signed(regs.angle_step));
                magnitude = (angle < 0) ? -angle : angle;
                counts = (magnitude <= longint'(regs.sector_half_angle))
                      && s_data.range_is_finite
                      && (s_data.range_mm >= regs.sensor_min_range)
                      && (s_data.range_mm <= regs.sensor_max_range);
                if (counts) begin
                    if (s_data.range_mm < scan_min)
                        scan_min = s_data.range_mm;
                    scan_hit = 1'b1;
                end
                // Hold the index at its bound on long scans
                if (scan_index < MAX_SAMPLES - 1)
                    scan_index++;

                if (s_data.last_of_scan) begin
                    if (!scan_hit) begin
                        report.proximity_status = STATUS_NO_DATA;
                        report.nearest_mm       = '0;
                    end else begin
                        if (scan_min <= regs.stop_limit_mm)
                            report.proximity_status = STATUS_STOP;
                        else if (scan_min <= regs.warn_limit_mm)
                            report.proximity_status = STATUS_WARNING;
                        else
                            report.proximity_status = STATUS_CLEAR;
                        report.nearest_mm = scan_min;
                    end
                    expected_reports.insert(expected_reports.size(), report);
                    scan_index = 0;
                    scan_min   = '1;
                    scan_hit   = 1'b0;
                end
            end
        end
        reports_pending = expected_reports.size();
    end

endmodule

// ----- test/tb_lidar_sector_proximity_check_core.sv -----
module tb_lidar_sector_proximity_check_core;
    import lspc_pkg::*;

    localparam int unsigned MAX_SAMPLES  = 4096;
    localparam int          RANDOM_ITEMS = 1620;
    localparam int          PHASE_ITEMS  = 130;
    localparam int          QUIET_ITEMS  = 200;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          CYCLE_LIMIT  = 400000;

    // No register lives at this index
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b1;
    out_item_t             m_data;

    int                    error_count;
    int                    reports_pending;
    int                    cycle_count = 0;
    int                    stall_left = 0;
    logic                  idle_on = 1'b1;

    // Thresholds last programmed, used to aim ranges at the edges
    logic [RANGE_W-1:0]    cur_stop;
    logic [RANGE_W-1:0]    cur_warn;
    logic [RANGE_W-1:0]    cur_min;
    logic [RANGE_W-1:0]    cur_max;

    lidar_sector_proximity_check_core #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    lspc_report_checker #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) report_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .error_count     (error_count),
        .reports_pending (reports_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stall the report channel in random-length bursts, started only while idle_on is set
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Enter and leave at a falling edge; valid is left high for the caller
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            cfg_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // Program every register, with junk above each field narrower than the data bus
    task automatic program_regs(input logic [RANGE_W-1:0] stop_mm,
                                input logic [RANGE_W-1:0] warn_mm,
                                input logic [HALF_W-1:0]  half,
                                input logic [ANGLE_W-1:0] start,
                                input logic [ANGLE_W-1:0] step,
                                input logic [RANGE_W-1:0] min_mm,
                                input logic [RANGE_W-1:0] max_mm);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_STOP_LIMIT, {junk[18:16], stop_mm});
        write_reg(CFG_WARN_LIMIT, {junk[15:13], warn_mm});
        write_reg(CFG_SECTOR_HALF_ANGLE, {junk[12], half});
        write_reg(CFG_START_ANGLE, start);
        write_reg(CFG_ANGLE_STEP, step);
        write_reg(CFG_SENSOR_MIN_RANGE, {junk[11:9], min_mm});
        write_reg(CFG_SENSOR_MAX_RANGE, {junk[8:6], max_mm});
        write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        cur_stop = stop_mm;
        cur_warn = warn_mm;
        cur_min  = min_mm;
        cur_max  = max_mm;
    endtask

    // Offer one sample, with an optional gap ahead of it
    task automatic push_sample(input logic [RANGE_W-1:0] range_mm,
                               input logic finite,
                               input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{range_mm: range_mm, range_is_finite: finite, last_of_scan: last};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Wait out every pending report, then let the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        while (reports_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [RANGE_W-1:0] near(input logic [RANGE_W-1:0] edge_mm);
        int v;
        v = int'(edge_mm) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[RANGE_W-1:0];
    endfunction

    function automatic logic [RANGE_W-1:0] pick_range();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return RANGE_W'($urandom);
            4:       return near(cur_stop);
            5:       return near(cur_warn);
            6:       return near(cur_min);
            default: return near(cur_max);
        endcase
    endfunction

    function automatic logic [RANGE_W-1:0] pick_dist();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return RANGE_W'($urandom);
            default: return RANGE_W'($urandom_range(0, 2000));
        endcase
    endfunction

    function automatic logic [ANGLE_W-1:0] pick_angle(input int span);
        case ($urandom_range(0, 4))
            0:       return ANGLE_W'(-262144);
            1:       return ANGLE_W'(262143);
            2:       return ANGLE_W'($urandom);
            3:       return '0;
            default: return ANGLE_W'(int'($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    initial begin : stimulus
        int                 random_sent;
        int                 budget;
        int                 len;
        logic [HALF_W-1:0]  half;
        logic [RANGE_W-1:0] lo;
        logic [RANGE_W-1:0] hi;

        cur_stop = 16'd350;
        cur_warn = 16'd700;
        cur_min  = 16'd0;
        cur_max  = 16'hFFFF;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Defaults: sample zero lies far outside the sector
        push_sample(16'd100, 1'b1, 1'b1);
        drain();

        // Fixed angle on the sector edge; status thresholds and extremes
        program_regs(16'd350, 16'd700, 18'd1000, 19'sd1000, 19'sd0, 16'd0, 16'hFFFF);
        push_sample(16'hFFFF, 1'b1, 1'b1);
        push_sample(16'd0, 1'b1, 1'b1);
        push_sample(16'd700, 1'b1, 1'b1);
        push_sample(16'd701, 1'b1, 1'b1);
        push_sample(16'd350, 1'b1, 1'b1);
        push_sample(16'd351, 1'b1, 1'b1);
        push_sample(16'd500, 1'b0, 1'b0);
        push_sample(16'd800, 1'b1, 1'b1);
        push_sample(16'd100, 1'b0, 1'b1);
        drain();

        // One unit outside the sector, then the negative edge
        program_regs(16'd350, 16'd700, 18'd999, 19'sd1000, 19'sd0, 16'd0, 16'hFFFF);
        push_sample(16'd100, 1'b1, 1'b1);
        drain();
        program_regs(16'd350, 16'd700, 18'd1000, -19'sd1000, 19'sd0, 16'd0, 16'hFFFF);
        push_sample(16'd100, 1'b1, 1'b1);
        drain();

        // Range window edges, then an inverted window
        program_regs(16'd350, 16'd700, 18'd1000, 19'sd0, 19'sd0, 16'd200, 16'd300);
        push_sample(16'd199, 1'b1, 1'b0);
        push_sample(16'd301, 1'b1, 1'b0);
        push_sample(16'd200, 1'b1, 1'b1);
        push_sample(16'd300, 1'b1, 1'b1);
        drain();
        program_regs(16'd350, 16'd700, 18'd1000, 19'sd0, 19'sd0, 16'd301, 16'd300);
        push_sample(16'd300, 1'b1, 1'b1);
        push_sample(16'd301, 1'b1, 1'b1);
        drain();

        // Stop threshold above warning: stop wins
        program_regs(16'd800, 16'd500, 18'd1000, 19'sd0, 19'sd0, 16'd0, 16'hFFFF);
        push_sample(16'd600, 1'b1, 1'b1);
        push_sample(16'd900, 1'b1, 1'b1);
        drain();

        // Random phases: extreme settings first, quiet handshakes at the end
        random_sent = 0;
        for (int phase = 0; random_sent < RANDOM_ITEMS; phase++) begin
            if (RANDOM_ITEMS - random_sent <= QUIET_ITEMS)
                idle_on <= 1'b0;
            else
                idle_on <= ($urandom_range(0, 3) != 0);
            @(negedge aclk);
            if (phase == 0) begin
                program_regs('0, '0, '0, ANGLE_W'(-262144), ANGLE_W'(-262144), '0, '0);
            end else if (phase == 1) begin
                program_regs('1, '1, '1, ANGLE_W'(262143), ANGLE_W'(262143), '1, '1);
            end else begin
                case ($urandom_range(0, 3))
                    0:       half = '0;
                    1:       half = '1;
                    2:       half = HALF_W'($urandom);
                    default: half = HALF_W'($urandom_range(0, 30000));
                endcase
                case ($urandom_range(0, 3))
                    0:       begin lo = '0; hi = '1; end
                    1:       begin
                        lo = RANGE_W'($urandom_range(0, 2000));
                        hi = RANGE_W'($urandom);
                    end
                    2:       begin lo = RANGE_W'($urandom); hi = RANGE_W'($urandom); end
                    default: begin lo = '1; hi = '0; end
                endcase
                program_regs(pick_dist(), pick_dist(), half, pick_angle(20000),
                             pick_angle(3000), lo, hi);
            end

            budget = 0;
            while (budget < PHASE_ITEMS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 90)
                                                  : $urandom_range(1, 20);
                for (int i = 0; i < len; i++)
                    push_sample(pick_range(), $urandom_range(0, 7) != 0, i == len - 1);
                budget += len;
            end
            random_sent += budget;
            drain();
        end

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
